>>> sv/knq_pkg.sv
package knq_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 33;
    localparam int SQ_W    = 32;
    localparam int RANK_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK    = 2'd2;

    localparam logic signed [COORD_W-1:0] QUERY_X_RST = 16'sd66;
    localparam logic signed [COORD_W-1:0] QUERY_Y_RST = 16'sd14;
    localparam logic [RANK_W-1:0]         RANK_RST    = 7'd2;

    typedef struct packed {
        logic [DIST_W-1:0]         dist_sq;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic mul_x;
        logic mul_y;
    } sqd_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_STORE,
        ST_SEL_INIT,
        ST_PART_START,
        ST_PIVOT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_END_RD,
        ST_END_SW,
        ST_END_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_OUT
    } state_t;

endpackage

>>> sv/knq_ram.sv
module knq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/knq_sqdist.sv
module knq_sqdist (
    input  logic                                  clk,
    input  knq_pkg::sqd_ctl_t                     ctl,
    input  logic signed [knq_pkg::COORD_W-1:0]    point_x,
    input  logic signed [knq_pkg::COORD_W-1:0]    point_y,
    input  logic signed [knq_pkg::COORD_W-1:0]    query_x,
    input  logic signed [knq_pkg::COORD_W-1:0]    query_y,
    output logic [knq_pkg::DIST_W-1:0]            distance
);

    logic signed [knq_pkg::COORD_W:0]     dx;
    logic signed [knq_pkg::COORD_W:0]     dy;
    logic signed [knq_pkg::COORD_W:0]     operand;
    logic signed [2*knq_pkg::COORD_W+1:0] product;
    logic [knq_pkg::SQ_W-1:0]             sq_x_reg;
    logic [knq_pkg::SQ_W-1:0]             sq_y_reg;

    // One squaring multiplier serves both axes on consecutive cycles.
    assign dx      = {point_x[knq_pkg::COORD_W-1], point_x} - {query_x[knq_pkg::COORD_W-1], query_x};
    assign dy      = {point_y[knq_pkg::COORD_W-1], point_y} - {query_y[knq_pkg::COORD_W-1], query_y};
    assign operand = ctl.mul_x ? dx : dy;
    assign product = operand * operand;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_x)
        begin
            sq_x_reg <= product[knq_pkg::SQ_W-1:0];
        end
        if (ctl.mul_y)
        begin
            sq_y_reg <= product[knq_pkg::SQ_W-1:0];
        end
    end

    assign distance = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

endmodule

>>> sv/knq_ctrl.sv
module knq_ctrl #(
    parameter int MAX_POINTS = knq_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [knq_pkg::COORD_W-1:0]  in_x,
    input  logic signed [knq_pkg::COORD_W-1:0]  in_y,
    input  logic                                in_last,
    input  logic [knq_pkg::RANK_W-1:0]          rank,
    output knq_pkg::sqd_ctl_t                   sqd_ctl,
    output logic signed [knq_pkg::COORD_W-1:0]  pt_x,
    output logic signed [knq_pkg::COORD_W-1:0]  pt_y,
    input  logic [knq_pkg::DIST_W-1:0]          distance,
    output logic                                mem_we,
    output logic [$clog2(MAX_POINTS)-1:0]       mem_waddr,
    output knq_pkg::entry_t                     mem_wdata,
    output logic [$clog2(MAX_POINTS)-1:0]       mem_raddr,
    input  knq_pkg::entry_t                     mem_rdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output knq_pkg::entry_t                     out_entry,
    output logic                                out_last
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = ((CW > knq_pkg::RANK_W) ? CW : knq_pkg::RANK_W) + 2;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_POINTS);

    knq_pkg::state_t state_reg, state_next;

    logic signed [knq_pkg::COORD_W-1:0] px_reg, px_next;
    logic signed [knq_pkg::COORD_W-1:0] py_reg, py_next;
    logic                               last_reg, last_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic signed [SW-1:0]               lo_reg, lo_next;
    logic signed [SW-1:0]               hi_reg, hi_next;
    logic signed [SW-1:0]               k_reg, k_next;
    logic signed [SW-1:0]               scan_reg, scan_next;
    logic signed [SW-1:0]               fill_reg, fill_next;
    logic [CW-1:0]                      emit_reg, emit_next;
    logic [CW-1:0]                      idx_reg, idx_next;
    knq_pkg::entry_t                    piv_reg, piv_next;
    knq_pkg::entry_t                    tmp_reg, tmp_next;
    knq_pkg::entry_t                    out_reg, out_next;
    logic                               out_last_reg, out_last_next;

    logic signed [SW-1:0] count_s;
    logic signed [SW-1:0] rank_s;
    logic signed [SW-1:0] fill_m1;
    logic [CW-1:0]        idx_p1;

    assign count_s = SW'($signed({2'b00, count_reg}));
    assign rank_s  = SW'($signed({2'b00, rank}));
    assign fill_m1 = fill_reg - SW'(1);
    assign idx_p1  = idx_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= knq_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        scan_reg     <= scan_next;
        fill_reg     <= fill_next;
        emit_reg     <= emit_next;
        idx_reg      <= idx_next;
        piv_reg      <= piv_next;
        tmp_reg      <= tmp_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        last_next     = last_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        k_next        = k_reg;
        scan_next     = scan_reg;
        fill_next     = fill_reg;
        emit_next     = emit_reg;
        idx_next      = idx_reg;
        piv_next      = piv_reg;
        tmp_next      = tmp_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        sqd_ctl       = '0;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[IW-1:0];
        mem_wdata     = '{dist_sq: distance, y: py_reg, x: px_reg};
        mem_raddr     = scan_reg[IW-1:0];

        case (state_reg)
            knq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    px_next   = in_x;
                    py_next   = in_y;
                    last_next = in_last;
                    if (count_reg != COUNT_MAX)
                    begin
                        state_next = knq_pkg::ST_SQX;
                    end
                    else if (in_last)
                    begin
                        state_next = knq_pkg::ST_SEL_INIT;
                    end
                end
            end
            knq_pkg::ST_SQX:
            begin
                sqd_ctl.mul_x = 1'b1;
                state_next    = knq_pkg::ST_SQY;
            end
            knq_pkg::ST_SQY:
            begin
                sqd_ctl.mul_y = 1'b1;
                state_next    = knq_pkg::ST_STORE;
            end
            knq_pkg::ST_STORE:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = last_reg ? knq_pkg::ST_SEL_INIT : knq_pkg::ST_IDLE;
            end
            knq_pkg::ST_SEL_INIT:
            begin
                count_next = '0;
                lo_next    = '0;
                hi_next    = count_s - SW'(1);
                k_next     = rank_s - SW'(1);
                emit_next  = (rank_s < count_s) ? rank_s[CW-1:0] : count_reg;
                idx_next   = '0;
                if (rank == '0 || count_reg == '0)
                begin
                    state_next = knq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = knq_pkg::ST_PART_START;
                end
            end
            knq_pkg::ST_PART_START:
            begin
                mem_raddr = lo_reg[IW-1:0];
                if (hi_reg < lo_reg)
                begin
                    state_next = knq_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = knq_pkg::ST_PIVOT;
                end
            end
            knq_pkg::ST_PIVOT:
            begin
                piv_next   = mem_rdata;
                scan_next  = lo_reg + SW'(1);
                fill_next  = lo_reg + SW'(1);
                state_next = knq_pkg::ST_SCAN_RD;
            end
            knq_pkg::ST_SCAN_RD:
            begin
                mem_raddr = scan_reg[IW-1:0];
                if (scan_reg > hi_reg)
                begin
                    state_next = knq_pkg::ST_END_RD;
                end
                else
                begin
                    state_next = knq_pkg::ST_SCAN_CMP;
                end
            end
            knq_pkg::ST_SCAN_CMP:
            begin
                mem_raddr = fill_reg[IW-1:0];
                if (mem_rdata.dist_sq < piv_reg.dist_sq)
                begin
                    tmp_next   = mem_rdata;
                    state_next = knq_pkg::ST_SWAP_RD;
                end
                else
                begin
                    scan_next  = scan_reg + SW'(1);
                    state_next = knq_pkg::ST_SCAN_RD;
                end
            end
            knq_pkg::ST_SWAP_RD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = scan_reg[IW-1:0];
                mem_wdata  = mem_rdata;
                state_next = knq_pkg::ST_SWAP_WR;
            end
            knq_pkg::ST_SWAP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = fill_reg[IW-1:0];
                mem_wdata  = tmp_reg;
                fill_next  = fill_reg + SW'(1);
                scan_next  = scan_reg + SW'(1);
                state_next = knq_pkg::ST_SCAN_RD;
            end
            knq_pkg::ST_END_RD:
            begin
                mem_raddr  = fill_m1[IW-1:0];
                state_next = knq_pkg::ST_END_SW;
            end
            knq_pkg::ST_END_SW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg[IW-1:0];
                mem_wdata  = mem_rdata;
                state_next = knq_pkg::ST_END_WR;
            end
            knq_pkg::ST_END_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_m1[IW-1:0];
                mem_wdata = piv_reg;
                if (fill_m1 >= k_reg)
                begin
                    hi_next = fill_m1 - SW'(1);
                end
                else
                begin
                    lo_next = fill_reg;
                end
                state_next = knq_pkg::ST_PART_START;
            end
            knq_pkg::ST_EMIT_RD:
            begin
                mem_raddr  = idx_reg[IW-1:0];
                state_next = knq_pkg::ST_EMIT_LD;
            end
            knq_pkg::ST_EMIT_LD:
            begin
                out_next      = mem_rdata;
                out_last_next = (idx_p1 == emit_reg);
                state_next    = knq_pkg::ST_EMIT_OUT;
            end
            knq_pkg::ST_EMIT_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next   = idx_p1;
                    state_next = out_last_reg ? knq_pkg::ST_IDLE : knq_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = knq_pkg::ST_IDLE;
            end
        endcase
    end

    assign pt_x      = px_reg;
    assign pt_y      = py_reg;
    assign out_entry = out_reg;
    assign out_last  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("point count beyond store depth");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == knq_pkg::ST_SCAN_CMP) |-> (fill_reg <= scan_reg && scan_reg <= hi_reg))
        else $error("partition indexes out of order");

    a_pivot_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == knq_pkg::ST_END_WR) |-> (fill_reg > lo_reg && fill_m1 <= hi_reg))
        else $error("pivot placed outside its range");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result is pending");

endmodule

>>> sv/k_nearest_points_quickselect.sv
// Streams a set of 2-D points in on the s_ side and returns the nearest ones on the m_ side.
// Each request on s_ carries one point; s_tlast marks the final point of the set.
// After each point that is stored, s_tready stays low while the
// shared squaring multiplier is used once for each axis and the sum is written to the store.
// Points beyond MAX_POINTS are dropped, but a dropped point with s_tlast still ends the set.
// After the final point a quickselect pass runs on the store (one read and one write port);
// each partition reads its pivot, moves entries nearer than the pivot to the front of the
// range, places the pivot after them and keeps only the side that holds the rank.
// Then min(rank, count) results leave on m_, one at a time, the next read only after the
// current one is taken, with m_tlast on the final one; the store is empty for the next set.
// While selection runs or a result waits, s_tready stays low; a stalled m_ side
// simply holds the current result. Configuration writes on cfg_* take effect at once,
// so they belong between sets while the block is idle.
// Reset empties the store and loads query (66, 14) and rank 2.
module k_nearest_points_quickselect #(
    parameter int MAX_POINTS = knq_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // point_x, point_y
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [71:0]                       m_tdata,  // near_x, near_y, squared_distance
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [knq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [knq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IW = $clog2(MAX_POINTS);

    logic signed [knq_pkg::COORD_W-1:0] query_x_reg;
    logic signed [knq_pkg::COORD_W-1:0] query_y_reg;
    logic [knq_pkg::RANK_W-1:0]         rank_reg;

    knq_pkg::sqd_ctl_t                  sqd_ctl;
    logic signed [knq_pkg::COORD_W-1:0] pt_x;
    logic signed [knq_pkg::COORD_W-1:0] pt_y;
    logic [knq_pkg::DIST_W-1:0]         distance;
    logic                               mem_we;
    logic [IW-1:0]                      mem_waddr;
    knq_pkg::entry_t                    mem_wdata;
    logic [IW-1:0]                      mem_raddr;
    knq_pkg::entry_t                    mem_rdata;
    knq_pkg::entry_t                    out_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= knq_pkg::QUERY_X_RST;
            query_y_reg <= knq_pkg::QUERY_Y_RST;
            rank_reg    <= knq_pkg::RANK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                knq_pkg::CFG_QUERY_X: query_x_reg <= cfg_data;
                knq_pkg::CFG_QUERY_Y: query_y_reg <= cfg_data;
                knq_pkg::CFG_RANK:    rank_reg    <= cfg_data[knq_pkg::RANK_W-1:0];
                default:              ;
            endcase
        end
    end

    knq_sqdist u_sqdist (
        .clk      (clk),
        .ctl      (sqd_ctl),
        .point_x  (pt_x),
        .point_y  (pt_y),
        .query_x  (query_x_reg),
        .query_y  (query_y_reg),
        .distance (distance)
    );

    knq_ram #(
        .WIDTH (knq_pkg::ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    knq_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[15:0]),
        .in_y      (s_tdata[31:16]),
        .in_last   (s_tlast),
        .rank      (rank_reg),
        .sqd_ctl   (sqd_ctl),
        .pt_x      (pt_x),
        .pt_y      (pt_y),
        .distance  (distance),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (out_entry),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'b0, out_entry.dist_sq, out_entry.y, out_entry.x};

endmodule
